FILE: rtl/b36e_pkg.sv
package b36e_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned DIGITS_PER_WORD = 7;
  localparam int unsigned CNT_W = $clog2(DIGITS_PER_WORD);

  localparam logic [WORD_W-1:0] OFFSET_RESET = 32'd1000;

  // quotient by 36: q = (v * RECIP_36) >> RECIP_SHIFT, exact for every 32-bit v
  localparam int unsigned RECIP_W = 30;
  localparam logic [RECIP_W-1:0] RECIP_36 = 30'h38E38E39;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned PROD_W = WORD_W + RECIP_W;
  localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;
  localparam logic [DIGIT_W-1:0] RADIX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'h37;
  localparam logic [DIGIT_W-1:0] FIRST_ALPHA = 6'd10;

  typedef logic [4:0] bit_pos_t;

  // destination bit for each source bit
  localparam bit_pos_t PERM_POS [WORD_W] = '{
    5'd26, 5'd31, 5'd17, 5'd10, 5'd30, 5'd16, 5'd24, 5'd2,
    5'd29, 5'd8,  5'd20, 5'd15, 5'd28, 5'd11, 5'd13, 5'd4,
    5'd19, 5'd23, 5'd0,  5'd12, 5'd14, 5'd27, 5'd6,  5'd18,
    5'd21, 5'd3,  5'd9,  5'd7,  5'd22, 5'd1,  5'd25, 5'd5
  };

  function automatic logic [WORD_W-1:0] scatter_bits(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      r[PERM_POS[i]] = v[i];
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < FIRST_ALPHA) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA_BASE + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

FILE: rtl/b36e_digit_unit.sv
module b36e_digit_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load_valid,
  input  logic [b36e_pkg::WORD_W-1:0] load_value,
  output logic                        load_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b36e_pkg::CHAR_W-1:0] digit_char,
  output logic                        last_of_word
);
  import b36e_pkg::*;

  // division stage
  logic              busy;
  logic [WORD_W-1:0] rest;
  logic [CNT_W-1:0]  cnt;

  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;
  logic [DIGIT_W-1:0] quot_x36_lo;
  logic [DIGIT_W-1:0] digit;
  logic               out_free;
  logic               emit;
  logic               final_digit;

  assign prod        = PROD_W'(rest) * PROD_W'(RECIP_36);
  assign quot        = prod[PROD_W-1:RECIP_SHIFT];
  // remainder is below 36, so the low six bits of rest - 36 * quot give it
  assign quot_x36_lo = DIGIT_W'(quot[DIGIT_W-1:0] * RADIX);
  assign digit       = rest[DIGIT_W-1:0] - quot_x36_lo;

  assign out_free    = !out_valid || out_ready;
  assign emit        = busy && out_free;
  assign final_digit = (cnt == CNT_W'(DIGITS_PER_WORD - 1));
  assign load_ready  = !busy || (out_free && final_digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (emit) begin
      if (final_digit) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      rest <= load_value;
    end else if (emit) begin
      rest <= WORD_W'(quot);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      digit_char   <= digit_to_char(digit);
      last_of_word <= final_digit;
    end
  end

endmodule

FILE: rtl/bit_permute_base36_encoder_unit.sv
// Bit-permuting base-36 word encoder. Each request on the input channel is one
// 32-bit word (four password bytes, little-endian, last word zero padded). The
// unit adds the pre-add offset register (reset value 1000) modulo 2^32, scatters
// the bits of the sum through a fixed 32-entry permutation and writes the result
// as seven base-36 ASCII characters ('0'-'9', 'A'-'Z'), least significant digit
// first, one character per cycle on the output channel while it is not stalled;
// last_of_word marks the seventh character. Leading zero digits are always sent.
// The single digit unit peels off one digit per cycle with a reciprocal multiply
// and loads the next word with the last character of the current one. A word
// passes the add, permute, digit and output registers to its first character.
// Up to two further words are held in the add and permute stages while a word
// is digitised; the input keeps accepting while a character waits on a stalled
// output, until those stages are full. The offset register is written through
// the cfg channel, which is always ready; write it only while the unit is empty.
module bit_permute_base36_encoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [b36e_pkg::WORD_W-1:0] cfg_data,
  // word requests
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [b36e_pkg::WORD_W-1:0] packed_word,
  // character results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b36e_pkg::CHAR_W-1:0] digit_char,
  output logic                        last_of_word
);
  import b36e_pkg::*;

  logic [WORD_W-1:0] pre_add_offset;

  // stage 1: offset add
  logic              sum_valid;
  logic [WORD_W-1:0] sum;
  logic              sum_ready;

  // stage 2: bit scatter
  logic              perm_valid;
  logic [WORD_W-1:0] perm;
  logic              perm_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_add_offset <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pre_add_offset <= cfg_data;
    end
  end

  // each stage takes a new request when empty or when its content moves on
  assign sum_ready = !sum_valid || perm_ready;
  assign in_ready  = sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_ready) begin
      sum_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && sum_ready) begin
      sum <= packed_word + pre_add_offset;   // wraps modulo 2^32
    end
  end

  logic digit_load_ready;

  assign perm_ready = !perm_valid || digit_load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_valid <= 1'b0;
    end else if (perm_ready) begin
      perm_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && perm_ready) begin
      perm <= scatter_bits(sum);
    end
  end

  // stage 3 and output register: one base-36 digit per cycle while the output is not stalled
  b36e_digit_unit u_digit (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (perm_valid),
    .load_value   (perm),
    .load_ready   (digit_load_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_char   (digit_char),
    .last_of_word (last_of_word)
  );

endmodule
